[hdl/rgba_alpha_bleed_dilate_macros.svh]
// assertion helpers used by the block's control module
`ifndef RGBA_ALPHA_BLEED_DILATE_MACROS_SVH
`define RGBA_ALPHA_BLEED_DILATE_MACROS_SVH

// condition holds at every clock edge out of reset
`define RABD_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the cycle after the trigger
`define RABD_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/rabd_pkg.sv]
package rabd_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W = $clog2(MAX_WIDTH);   // column index
  localparam int WID_W = COL_W + 1;           // width value, up to MAX_WIDTH
  localparam int ROW_W = $clog2(MAX_HEIGHT);  // row index
  localparam int HGT_W = ROW_W + 1;           // height value, up to MAX_HEIGHT

  localparam int CFG_W   = 13;  // widest register
  localparam int PIX_W   = 32;
  localparam int REGW_W  = 12;  // width register
  localparam int REGH_W  = 13;  // height register

  typedef enum logic [1:0] {
    REG_WIDTH   = 2'd0,
    REG_HEIGHT  = 2'd1,
    REG_RESTORE = 2'd2
  } reg_idx_t;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  // per-transaction control from the sequencer to the line stores and the picker
  typedef struct packed {
    logic             emit;      // one result is produced
    logic             has_down;  // incoming pixel is the down neighbor
    logic             ok_up;
    logic             ok_left;
    logic             ok_right;
    logic             last;      // last pixel of the frame
    logic             restore;   // keep original alpha on filled pixels
    logic             mid_we;    // write incoming pixel into the middle line
    logic [COL_W-1:0] wr_col;    // middle line write column
    logic [COL_W-1:0] col;       // output column (upper line write column)
    logic [COL_W-1:0] rd_col;    // output column of the next cycle
  } ctl_t;

endpackage

[hdl/rabd_ctrl.sv]
`include "rgba_alpha_bleed_dilate_macros.svh"

module rabd_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic                           func,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [rabd_pkg::CFG_W-1:0]     cfg_data,
  output rabd_pkg::ctl_t                 ctl
);

  logic [rabd_pkg::REGW_W-1:0] width;
  logic [rabd_pkg::REGH_W-1:0] height;
  logic                        restore_alpha;
  logic [rabd_pkg::REGW_W-1:0] width_next;
  logic [rabd_pkg::REGH_W-1:0] height_next;
  logic                        restore_alpha_next;

  logic [rabd_pkg::COL_W-1:0] in_column, in_column_next;
  logic [rabd_pkg::ROW_W-1:0] in_row, in_row_next;
  logic [rabd_pkg::COL_W-1:0] out_column, out_column_next;
  logic [rabd_pkg::ROW_W-1:0] out_row, out_row_next;
  logic [rabd_pkg::WID_W-1:0] drain_due, drain_due_next;

  logic [rabd_pkg::WID_W-1:0] w_eff;
  logic [rabd_pkg::HGT_W-1:0] h_eff;
  logic                       out_col_wrap;
  logic                       emit, has_down, mid_we;

  // clamp the registers into the supported range
  always_comb begin
    if (width == '0) w_eff = rabd_pkg::WID_W'(1);
    else if (rabd_pkg::WID_W'(width) > rabd_pkg::WID_W'(rabd_pkg::MAX_WIDTH))
      w_eff = rabd_pkg::WID_W'(rabd_pkg::MAX_WIDTH);
    else w_eff = rabd_pkg::WID_W'(width);
    if (height == '0) h_eff = rabd_pkg::HGT_W'(1);
    else if (rabd_pkg::HGT_W'(height) > rabd_pkg::HGT_W'(rabd_pkg::MAX_HEIGHT))
      h_eff = rabd_pkg::HGT_W'(rabd_pkg::MAX_HEIGHT);
    else h_eff = rabd_pkg::HGT_W'(height);
  end

  assign out_col_wrap = (rabd_pkg::WID_W'(out_column) + rabd_pkg::WID_W'(1)) >= w_eff;

  always_comb begin
    width_next         = width;
    height_next        = height;
    restore_alpha_next = restore_alpha;
    in_column_next     = in_column;
    in_row_next        = in_row;
    out_column_next    = out_column;
    out_row_next       = out_row;
    drain_due_next     = drain_due;
    emit               = 1'b0;
    has_down           = 1'b0;
    mid_we             = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        rabd_pkg::REG_WIDTH, rabd_pkg::REG_HEIGHT: begin
          if (cfg_index == rabd_pkg::REG_WIDTH)
            width_next = cfg_data[rabd_pkg::REGW_W-1:0];
          else
            height_next = cfg_data[rabd_pkg::REGH_W-1:0];
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
          drain_due_next  = '0;
        end
        rabd_pkg::REG_RESTORE: restore_alpha_next = cfg_data[0];
        default: ;
      endcase
    end else if (accept) begin
      if (func == rabd_pkg::FUNC_DRAIN) begin
        if (drain_due != '0) begin
          emit           = 1'b1;
          drain_due_next = drain_due - rabd_pkg::WID_W'(1);
          if (drain_due == rabd_pkg::WID_W'(1)) begin
            out_column_next = '0;
            out_row_next    = '0;
          end else if (out_col_wrap) begin
            out_column_next = '0;
            out_row_next    = out_row + rabd_pkg::ROW_W'(1);
          end else begin
            out_column_next = out_column + rabd_pkg::COL_W'(1);
          end
        end
      end else if (drain_due == '0) begin
        mid_we = 1'b1;
        if (in_row != '0) begin
          emit     = 1'b1;
          has_down = 1'b1;
          if (out_col_wrap) begin
            out_column_next = '0;
            out_row_next    = out_row + rabd_pkg::ROW_W'(1);
          end else begin
            out_column_next = out_column + rabd_pkg::COL_W'(1);
          end
        end
        if ((rabd_pkg::WID_W'(in_column) + rabd_pkg::WID_W'(1)) >= w_eff) begin
          in_column_next = '0;
          if ((rabd_pkg::HGT_W'(in_row) + rabd_pkg::HGT_W'(1)) >= h_eff) begin
            // frame complete: last row is flushed by drain transactions
            in_row_next     = '0;
            drain_due_next  = w_eff;
            out_column_next = '0;
            out_row_next    = rabd_pkg::ROW_W'(h_eff - rabd_pkg::HGT_W'(1));
          end else begin
            in_row_next = in_row + rabd_pkg::ROW_W'(1);
          end
        end else begin
          in_column_next = in_column + rabd_pkg::COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width         <= rabd_pkg::REGW_W'(1);
      height        <= rabd_pkg::REGH_W'(1);
      restore_alpha <= 1'b0;
      in_column     <= '0;
      in_row        <= '0;
      out_column    <= '0;
      out_row       <= '0;
      drain_due     <= '0;
    end else begin
      width         <= width_next;
      height        <= height_next;
      restore_alpha <= restore_alpha_next;
      in_column     <= in_column_next;
      in_row        <= in_row_next;
      out_column    <= out_column_next;
      out_row       <= out_row_next;
      drain_due     <= drain_due_next;
    end
  end

  always_comb begin
    ctl.emit     = emit;
    ctl.has_down = has_down;
    ctl.ok_up    = out_row != '0;
    ctl.ok_left  = out_column != '0;
    ctl.ok_right = !out_col_wrap;
    ctl.last     = out_col_wrap &&
                   ((rabd_pkg::HGT_W'(out_row) + rabd_pkg::HGT_W'(1)) >= h_eff);
    ctl.restore  = restore_alpha;
    ctl.mid_we   = mid_we;
    ctl.wr_col   = emit ? out_column : in_column;
    ctl.col      = out_column;
    ctl.rd_col   = out_column_next;
  end

  `RABD_ALWAYS(a_out_col_range, rabd_pkg::WID_W'(out_column) < w_eff, "output column past width")
  `RABD_ALWAYS(a_in_col_range, rabd_pkg::WID_W'(in_column) < w_eff, "input column past width")
  `RABD_ALWAYS(a_drain_at_origin, (drain_due == '0) || (in_column == '0 && in_row == '0),
               "input counters moved during drain")
  `RABD_NEXT(a_width_restart, cfg_we && cfg_index == rabd_pkg::REG_WIDTH,
             drain_due == '0 && out_column == '0 && in_row == '0, "width write did not restart")

endmodule

[hdl/rabd_lines.sv]
module rabd_lines (
  input  logic                         clk,
  input  rabd_pkg::ctl_t               ctl,
  input  logic [rabd_pkg::PIX_W-1:0]   pix,
  output logic [rabd_pkg::PIX_W-1:0]   center,
  output logic [rabd_pkg::PIX_W-1:0]   right,
  output logic [rabd_pkg::PIX_W-1:0]   up
);

  logic [rabd_pkg::PIX_W-1:0] mid_mem [rabd_pkg::MAX_WIDTH];
  logic [rabd_pkg::PIX_W-1:0] up_mem  [rabd_pkg::MAX_WIDTH];
  logic [rabd_pkg::COL_W-1:0] rd_right;

  // column past the end wraps; its data is never used there
  assign rd_right = ctl.rd_col + rabd_pkg::COL_W'(1);

  // reads are write-first so a column written this cycle is seen next cycle
  always_ff @(posedge clk) begin
    if (ctl.mid_we) mid_mem[ctl.wr_col] <= pix;
    if (ctl.emit) up_mem[ctl.col] <= center;
    center <= (ctl.mid_we && ctl.wr_col == ctl.rd_col) ? pix : mid_mem[ctl.rd_col];
    right  <= (ctl.mid_we && ctl.wr_col == rd_right) ? pix : mid_mem[rd_right];
    up     <= (ctl.emit && ctl.col == ctl.rd_col) ? center : up_mem[ctl.rd_col];
  end

endmodule

[hdl/rabd_pick.sv]
module rabd_pick (
  input  logic                         clk,
  input  rabd_pkg::ctl_t               ctl,
  input  logic [rabd_pkg::PIX_W-1:0]   pix,
  input  logic [rabd_pkg::PIX_W-1:0]   center,
  input  logic [rabd_pkg::PIX_W-1:0]   right,
  input  logic [rabd_pkg::PIX_W-1:0]   up,
  output logic [rabd_pkg::PIX_W-1:0]   result
);

  logic [rabd_pkg::PIX_W-1:0] left;
  logic [7:0]                 fill_alpha;

  // left neighbor is the center of the previous result in the row
  always_ff @(posedge clk) begin
    if (ctl.emit) left <= center;
  end

  assign fill_alpha = ctl.restore ? center[31:24] : 8'hFF;

  always_comb begin
    result = center;
    if (center[31:24] == 8'h00) begin
      priority if (ctl.ok_up && up[31:24] != 8'h00)
        result = {fill_alpha, up[23:0]};
      else if (ctl.ok_left && left[31:24] != 8'h00)
        result = {fill_alpha, left[23:0]};
      else if (ctl.ok_right && right[31:24] != 8'h00)
        result = {fill_alpha, right[23:0]};
      else if (ctl.has_down && pix[31:24] != 8'h00)
        result = {fill_alpha, pix[23:0]};
      else
        result = center;
    end
  end

endmodule

[hdl/rgba_alpha_bleed_dilate.sv]
// output: a result leaves the output register in the cycle after the transaction
//   that produces it; pixel results trail the input by one row
// throughput: one transaction per cycle while the sink does not hold the output register
// reset: counters and drain count clear, width and height read 1, restore_alpha 0;
//   the line stores are not cleared and need no clearing pass
module rgba_alpha_bleed_dilate (
  input  logic                         clk,
  input  logic                         rst,
  // pixel / drain input
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [31:0]                  s_tdata,   // red, green, blue, alpha
  input  logic                         s_tuser,   // func
  // result output
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,   // out_red, out_green, out_blue, out_alpha
  output logic                         m_tlast,   // frame_end
  // configuration write port
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [rabd_pkg::CFG_W-1:0]   cfg_data
);

  rabd_pkg::ctl_t             ctl;
  logic                       accept;
  logic [rabd_pkg::PIX_W-1:0] center, right, up, result;

  // the output register frees up in the same cycle it is taken
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // counters, drain bookkeeping and configuration registers
  rabd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .func      (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl)
  );

  // upper and middle line stores, read at the next output column ahead of its use
  rabd_lines u_lines (
    .clk    (clk),
    .ctl    (ctl),
    .pix    (s_tdata),
    .center (center),
    .right  (right),
    .up     (up)
  );

  // neighbor choice in the order up, left, right, down
  rabd_pick u_pick (
    .clk    (clk),
    .ctl    (ctl),
    .pix    (s_tdata),
    .center (center),
    .right  (right),
    .up     (up),
    .result (result)
  );

  // output register: holds a result until the sink takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && ctl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && ctl.emit) begin
      m_tdata <= result;
      m_tlast <= ctl.last;
    end
  end

endmodule
